### design/escape_time_fractal_pixel_core_assert.svh
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core_assert.svh
// Assertion macros for the escape-time fractal pixel core.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_CORE_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ETF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etf assertion failed");
// next-cycle implication
`define ETF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etf assertion failed");
`else
`define ETF_ASSERT_NOW(lbl, ante, cons)
`define ETF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// Types and constants shared by the escape-time fractal pixel core.
// ----------------------------------------------------------------------------
package etf_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 24;
    localparam int CNT_W     = 16;
    localparam int RAD_W     = 31;
    localparam int CH_W      = 8;
    localparam int CFG_IDX_W = 3;
    localparam int Q_W       = 10;  // quotient of 1020*v/d never exceeds 1020
    localparam int NUM_W     = 26;  // 1020 * 65535 fits

    localparam logic [CFG_IDX_W-1:0] REG_JULIA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_R = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAXIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd4;

    localparam logic [CNT_W-1:0] MAXIT_RST  = 16'd15;
    localparam logic [RAD_W-1:0] RADIUS_RST = 31'd335544320;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_real;
        logic signed [COORD_W-1:0] point_imag;
    } in_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] iteration_count;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } out_word_t;

    typedef struct packed {
        logic                      julia_mode;
        logic signed [COORD_W-1:0] seed_real;
        logic signed [COORD_W-1:0] seed_imag;
        logic [CNT_W-1:0]          max_iterations;
        logic [RAD_W-1:0]          escape_radius_sq;
    } cfg_t;

    // word moving down the divider chain
    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] dsh;
        logic [Q_W-1:0]   q;
        logic [CNT_W-1:0] d;
        logic [CNT_W-1:0] v;
        logic             black;
    } div_word_t;

endpackage

### design/etf_div_cell.sv
// ----------------------------------------------------------------------------
// etf_div_cell
// One restoring-division cell: one quotient bit, registered hand-off.
// ----------------------------------------------------------------------------
module etf_div_cell
    import etf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_word_t din,
    output div_word_t dout
);

    div_word_t dout_reg;
    div_word_t dout_next;
    logic      ge;

    always_comb
    begin
        ge        = (din.rem >= din.dsh);
        dout_next = din;
        dout_next.rem = ge ? (din.rem - din.dsh) : din.rem;
        dout_next.q   = {din.q[Q_W-2:0], ge};
        dout_next.dsh = din.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

### design/etf_iter.sv
// ----------------------------------------------------------------------------
// etf_iter
// Escape-time iteration z = z*z + c on one shared signed multiplier.
// ----------------------------------------------------------------------------
module etf_iter
    import etf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             start,
    input  in_word_t         point,
    output logic             idle,
    output logic             done,
    output logic [CNT_W-1:0] count,
    input  logic             take
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_A    = 4'd2;
    localparam logic [3:0] S_B    = 4'd3;
    localparam logic [3:0] S_TOP  = 4'd4;
    localparam logic [3:0] S_C    = 4'd5;
    localparam logic [3:0] S_D    = 4'd6;
    localparam logic [3:0] S_E    = 4'd7;
    localparam logic [3:0] S_F    = 4'd8;
    localparam logic [3:0] S_G    = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam int P_W = 2 * COORD_W;
    localparam int S_LO = FRAC_W;
    localparam int S_HI = COORD_W + FRAC_W - 1;

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic signed [COORD_W-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [COORD_W-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [COORD_W-1:0] rr_reg, rr_next, ii_reg, ii_next;
    logic signed [COORD_W-1:0] nr_reg, nr_next, ni_reg, ni_next;
    logic signed [P_W-1:0]    prod_reg;
    logic signed [COORD_W-1:0] mul_a, mul_b;

    logic [COORD_W-1:0] slice;
    logic               povf;
    logic [COORD_W-1:0] tdiff, ri2;
    logic [COORD_W:0]   nr_sum, ni_sum, mag;
    logic               add_ovf;

    // product scaled by the fraction width; overflow when the dropped top bits
    // are not all copies of the new sign bit
    assign slice = prod_reg[S_HI:S_LO];
    assign povf  = !((&prod_reg[P_W-1:S_HI]) || !(|prod_reg[P_W-1:S_HI]));

    always_comb
    begin
        tdiff   = rr_reg - ii_reg;
        nr_sum  = {tdiff[COORD_W-1], tdiff} + {cr_reg[COORD_W-1], cr_reg};
        ri2     = {slice[COORD_W-2:0], 1'b0};
        ni_sum  = {ri2[COORD_W-1], ri2} + {ci_reg[COORD_W-1], ci_reg};
        add_ovf = (nr_sum[COORD_W] != nr_sum[COORD_W-1])
                  || (slice[COORD_W-1] != slice[COORD_W-2])
                  || (ni_sum[COORD_W] != ni_sum[COORD_W-1]);
        mag     = {1'b0, rr_reg} + {1'b0, ii_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        nr_next    = nr_reg;
        ni_next    = ni_reg;
        mul_a      = zr_reg;
        mul_b      = zr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    if (cfg.julia_mode)
                    begin
                        zr_next = point.point_real;
                        zi_next = point.point_imag;
                        cr_next = cfg.seed_real;
                        ci_next = cfg.seed_imag;
                    end
                    else
                    begin
                        zr_next = cfg.seed_real;
                        zi_next = cfg.seed_imag;
                        cr_next = point.point_real;
                        ci_next = point.point_imag;
                    end
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                state_next = S_A;
            end
            S_A:
            begin
                rr_next    = slice;
                ovf_next   = povf;
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                state_next = S_B;
            end
            S_B:
            begin
                ii_next    = slice;
                ovf_next   = ovf_reg || povf;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                mul_b = zi_reg;
                if ((cnt_reg == cfg.max_iterations) || ovf_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_C;
                end
            end
            S_C:
            begin
                nr_next    = nr_sum[COORD_W-1:0];
                ni_next    = ni_sum[COORD_W-1:0];
                ovf_next   = povf || add_ovf;
                state_next = S_D;
            end
            S_D:
            begin
                mul_a = nr_reg;
                mul_b = nr_reg;
                state_next = ovf_reg ? S_DONE : S_E;
            end
            S_E:
            begin
                rr_next    = slice;
                ovf_next   = povf;
                mul_a      = ni_reg;
                mul_b      = ni_reg;
                state_next = S_F;
            end
            S_F:
            begin
                ii_next    = slice;
                ovf_next   = ovf_reg || povf;
                state_next = S_G;
            end
            S_G:
            begin
                if (ovf_reg || (mag > {2'b00, cfg.escape_radius_sq}))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    zr_next    = nr_reg;
                    zi_next    = ni_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_TOP;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        cr_reg   <= cr_next;
        ci_reg   <= ci_next;
        rr_reg   <= rr_next;
        ii_reg   <= ii_next;
        nr_reg   <= nr_next;
        ni_reg   <= ni_next;
        prod_reg <= mul_a * mul_b;
    end

    assign idle  = (state_reg == S_IDLE);
    assign done  = (state_reg == S_DONE);
    assign count = cnt_reg;

endmodule

### design/escape_time_fractal_pixel_core.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core
// Mandelbrot / Julia escape-time pixel engine with a jet color map.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one complex point (signed Q8.24).
// Output channel out_valid/out_ready returns the iteration count and an RGB
// color. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// Unknown indexes are dropped. One point is in the iteration engine at a
// time. The engine works out the start squares, then each iteration on its
// single shared 32x32 multiplier, then the final check and hand-off. The
// count then walks a 10-cell division chain and one color register.
// A new point is taken as soon as the engine has handed off the previous
// one, while its color is still in the chain or waiting at the output.
// If the receiver stalls, the finished word holds in the output register and
// the engine holds its next result until the output frees up.
// Reset clears all handshake state and loads the register defaults.
// ----------------------------------------------------------------------------
`include "escape_time_fractal_pixel_core_assert.svh"

module escape_time_fractal_pixel_core
    import etf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_data
);

    cfg_t             cfg_reg;
    logic             iter_idle, iter_done, handoff, chain_busy;
    logic [CNT_W-1:0] iter_count;
    div_word_t        div_in_reg, div_in_next;
    div_word_t        taps [0:Q_W];
    div_word_t        fin;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_reg, out_next;

    logic [CNT_W-1:0]   dm1;
    logic [Q_W:0]       qc;
    logic [CNT_W+1:0]   v4, d2, d3;
    logic [Q_W:0]       g_lo, b_hi, r_mid;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.julia_mode       <= 1'b0;
            cfg_reg.seed_real        <= '0;
            cfg_reg.seed_imag        <= '0;
            cfg_reg.max_iterations   <= MAXIT_RST;
            cfg_reg.escape_radius_sq <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_JULIA:  cfg_reg.julia_mode       <= cfg_data[0];
                REG_SEED_R: cfg_reg.seed_real        <= cfg_data;
                REG_SEED_I: cfg_reg.seed_imag        <= cfg_data;
                REG_MAXIT:  cfg_reg.max_iterations   <= cfg_data[CNT_W-1:0];
                REG_RADIUS: cfg_reg.escape_radius_sq <= cfg_data[RAD_W-1:0];
                default:    ;
            endcase
        end
    end

    etf_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .start (in_valid && in_ready),
        .point (in_data),
        .idle  (iter_idle),
        .done  (iter_done),
        .count (iter_count),
        .take  (handoff)
    );

    assign in_ready = iter_idle;

    always_comb
    begin
        chain_busy = 1'b0;
        for (int k = 0; k <= Q_W; k++)
        begin
            chain_busy = chain_busy || taps[k].valid;
        end
    end

    // only one word in the chain at a time, and the output is free at entry
    assign handoff = iter_done && !chain_busy && (!out_valid_reg || out_ready);

    always_comb
    begin
        dm1               = cfg_reg.max_iterations - 1'b1;
        div_in_next       = div_in_reg;
        div_in_next.valid = handoff;
        div_in_next.v     = iter_count;
        div_in_next.d     = dm1;
        div_in_next.q     = '0;
        div_in_next.rem   = ({{(NUM_W-CNT_W){1'b0}}, iter_count} << 10)
                          - ({{(NUM_W-CNT_W){1'b0}}, iter_count} << 2);
        div_in_next.dsh   = {{(NUM_W-CNT_W){1'b0}}, dm1} << (Q_W - 1);
        div_in_next.black = (cfg_reg.max_iterations < 16'd2)
                            || (iter_count == cfg_reg.max_iterations);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_in_reg <= '0;
        end
        else
        begin
            div_in_reg <= div_in_next;
        end
    end

    assign taps[0] = div_in_reg;

    genvar gi;
    generate
        for (gi = 0; gi < Q_W; gi++)
        begin : g_cell
            etf_div_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .din   (taps[gi]),
                .dout  (taps[gi+1])
            );
        end
    endgenerate

    assign fin = taps[Q_W];

    // jet bands
    always_comb
    begin
        qc    = {1'b0, fin.q} + {{Q_W{1'b0}}, (fin.rem != '0)};
        v4    = {fin.v, 2'b00};
        d2    = {1'b0, fin.d, 1'b0};
        d3    = d2 + {2'b00, fin.d};
        g_lo  = 11'd1020 - qc;
        b_hi  = 11'd510 - qc;
        r_mid = {1'b0, fin.q} - 11'd510;

        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (fin.valid)
        begin
            out_valid_next           = 1'b1;
            out_next.iteration_count = fin.v;
            out_next.red             = '0;
            out_next.green           = '0;
            out_next.blue            = '0;
            if (!fin.black)
            begin
                if (v4 < {2'b00, fin.d})
                begin
                    out_next.green = fin.q[CH_W-1:0];
                    out_next.blue  = 8'd255;
                end
                else if (v4 < d2)
                begin
                    out_next.green = 8'd255;
                    out_next.blue  = b_hi[CH_W-1:0];
                end
                else if (v4 < d3)
                begin
                    out_next.red   = r_mid[CH_W-1:0];
                    out_next.green = 8'd255;
                end
                else
                begin
                    out_next.red   = 8'd255;
                    out_next.green = g_lo[CH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `ETF_ASSERT_NOW(a_exit_free, fin.valid, !out_valid_reg)
    `ETF_ASSERT_NEXT(a_handoff_enters, handoff, div_in_reg.valid && !iter_done)
    `ETF_ASSERT_NOW(a_jet_no_magenta, out_valid_reg, out_reg.red == '0 || out_reg.blue == '0)

endmodule

### tb/sv/tb_escape_time_fractal_pixel_core.sv
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_pixel_core
// Self-checking bench for the escape-time fractal pixel core.
// ----------------------------------------------------------------------------
// Points are pushed through the valid/ready input while a local model of the
// fixed-point iteration and jet color map predicts each output word. A short
// table of directed points runs first, then random phases under several
// register settings with random idling on both sides, a long output stall
// and a drain pause.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_pixel_core;
    import etf_pkg::*;

    localparam int DRAIN_CYCLES = 600;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_word_t            out_data;

    escape_time_fractal_pixel_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // shadow copy of the register file
    logic                      sh_julia;
    logic signed [COORD_W-1:0] sh_seed_r;
    logic signed [COORD_W-1:0] sh_seed_i;
    logic [CNT_W-1:0]          sh_maxit;
    logic [RAD_W-1:0]          sh_radius;

    out_word_t pixel_q[$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_off;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #80000000;
        $display("escape_time_fractal_pixel_core regression: fail");
        $finish;
    end

    // (a*b) >> FRAC_W, floor; ok clears when the result leaves COORD_W bits
    function automatic logic signed [127:0] fx_mul(logic signed [127:0] a,
                                                  logic signed [127:0] b,
                                                  ref bit ok);
        logic signed [127:0] p;
        p = (a * b) >>> FRAC_W;
        if (p > 128'sd2147483647 || p < -128'sd2147483648) ok = 0;
        return p;
    endfunction

    function automatic logic signed [127:0] fx_add(logic signed [127:0] a,
                                                  logic signed [127:0] b,
                                                  ref bit ok);
        logic signed [127:0] s;
        s = a + b;
        if (s > 128'sd2147483647 || s < -128'sd2147483648) ok = 0;
        return s;
    endfunction

    function automatic int unsigned escape_count(logic signed [63:0] zr0,
                                                 logic signed [63:0] zi0,
                                                 logic signed [63:0] cr,
                                                 logic signed [63:0] ci);
        logic signed [127:0] zr, zi, rr, ii, ri, nr, ni, mr, mi;
        int unsigned n;
        bit ok;
        zr = zr0;
        zi = zi0;
        n = 0;
        while (n < sh_maxit)
        begin
            ok = 1;
            rr = fx_mul(zr, zr, ok);
            ii = fx_mul(zi, zi, ok);
            ri = fx_mul(zr, zi, ok);
            if (!ok) break;
            nr = fx_add(fx_add(rr, -ii, ok), cr, ok);
            ni = fx_add(fx_add(ri, ri, ok), ci, ok);
            if (!ok) break;
            mr = fx_mul(nr, nr, ok);
            mi = fx_mul(ni, ni, ok);
            if (!ok) break;
            if (mr + mi > 128'(sh_radius)) break;
            zr = nr;
            zi = ni;
            n++;
        end
        return n;
    endfunction

    function automatic out_word_t predict_pixel(in_word_t pt);
        out_word_t w;
        int unsigned n;
        longint unsigned d, num, q, qc, v4;
        if (sh_julia)
            n = escape_count(pt.point_real, pt.point_imag, sh_seed_r, sh_seed_i);
        else
            n = escape_count(sh_seed_r, sh_seed_i, pt.point_real, pt.point_imag);
        w = '0;
        w.iteration_count = n[CNT_W-1:0];
        if (sh_maxit >= 2 && n < sh_maxit)
        begin
            d   = sh_maxit - 1;
            num = 1020 * n;
            q   = num / d;
            qc  = q + 64'((num % d) != 0);
            v4  = 4 * n;
            if (v4 < d)
            begin
                w.green = 8'(q); w.blue = 8'd255;
            end
            else if (v4 < 2 * d)
            begin
                w.green = 8'd255; w.blue = 8'(510 - qc);
            end
            else if (v4 < 3 * d)
            begin
                w.red = 8'(q - 510); w.green = 8'd255;
            end
            else
            begin
                w.red = 8'd255; w.green = 8'(1020 - qc);
            end
        end
        return w;
    endfunction

    // write enable is dropped by the next sending phase
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_JULIA:  sh_julia  = val[0];
            REG_SEED_R: sh_seed_r = val;
            REG_SEED_I: sh_seed_i = val;
            REG_MAXIT:  sh_maxit  = val[CNT_W-1:0];
            REG_RADIUS: sh_radius = val[RAD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // expected word is queued when the point is taken, at the accepting edge
    task automatic send_point(in_word_t pt);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixel_q.push_back(predict_pixel(pt));
    endtask

    // check a typed expected word against the predictor, then send the point
    task automatic send_known(in_word_t pt, out_word_t exp_w);
        out_word_t p;
        p = predict_pixel(pt);
        if (p !== exp_w)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees: predicted %h typed %h", p, exp_w);
        end
        send_point(pt);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            default: return $signed($urandom_range(0, 32'h0600_0000)) - 32'sh0300_0000;
        endcase
    endfunction

    task automatic random_points(int count);
        in_word_t pt;
        cfg_we <= 1'b0;
        repeat (count)
        begin
            pt.point_real = rand_coord();
            pt.point_imag = rand_coord();
            send_point(pt);
        end
    endtask

    // output side: random stalls, optional long hold-off
    initial
    begin
        out_word_t exp_w;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", out_data);
                end
                else
                begin
                    exp_w = pixel_q.pop_front();
                    if (out_data.iteration_count !== exp_w.iteration_count ||
                        out_data.red !== exp_w.red || out_data.green !== exp_w.green ||
                        out_data.blue !== exp_w.blue)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %h %h %h, got %0d %h %h %h",
                                     exp_w.iteration_count, exp_w.red, exp_w.green,
                                     exp_w.blue, out_data.iteration_count,
                                     out_data.red, out_data.green, out_data.blue);
                    end
                end
            end
            out_ready <= !hold_off &&
                         !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        wait (rst_n);
        hold_off = 1'b0;
    end

    typedef struct {
        logic [COORD_W-1:0] re;
        logic [COORD_W-1:0] im;
        bit                 typed;
        out_word_t          exp_w;
    } point_row_t;

    point_row_t rows[] = '{
        // origin never escapes at reset settings: count at limit, black
        '{32'h0000_0000, 32'h0000_0000, 1, '{16'd15, 8'd0, 8'd0, 8'd0}},
        // extremes: the new z overflows when squared, escape at count zero (blue)
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, '{16'd0, 8'd0, 8'd0, 8'd255}},
        '{32'h8000_0000, 32'h8000_0000, 1, '{16'd0, 8'd0, 8'd0, 8'd255}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1, '{16'd0, 8'd0, 8'd0, 8'd255}},
        '{32'h8000_0000, 32'h0000_0000, 0, '0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 0, '0},
        '{32'hFE00_0000, 32'h0000_0000, 0, '0},
        '{32'h0040_0000, 32'h0100_0000, 0, '0},
        '{32'hFF40_0000, 32'h00A0_0000, 0, '0},
        '{32'h0060_0000, 32'h0000_0000, 0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 0, '0}
    };

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; in_data = '0;
        mismatches = 0;
        send_idle_pct = 13; recv_idle_pct = 64;
        sh_julia = 1'b0; sh_seed_r = '0; sh_seed_i = '0;
        sh_maxit = MAXIT_RST; sh_radius = RADIUS_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            in_word_t pt;
            pt.point_real = rows[i].re;
            pt.point_imag = rows[i].im;
            if (rows[i].typed) send_known(pt, rows[i].exp_w);
            else send_point(pt);
        end
        random_points(150); // begins once the long output hold-off is over
        wait_idle();

        // Julia with a classic constant, limit 2 (narrowest scale)
        write_reg(REG_JULIA, 32'd1);
        write_reg(REG_SEED_R, 32'hFF35_C28F);
        write_reg(REG_SEED_I, 32'h0029_5E9E);
        write_reg(REG_MAXIT, 32'd2);
        write_reg(REG_NONE, 32'hDEAD_BEEF);  // unknown index, dropped
        random_points(100);
        wait_idle();

        // limit one and zero: empty scale
        write_reg(REG_MAXIT, 32'hFFFF_0001);
        random_points(20);
        wait_idle();
        write_reg(REG_MAXIT, 32'd0);
        random_points(20);
        wait_idle();

        send_idle_pct = 64; recv_idle_pct = 13;
        write_reg(REG_JULIA, 32'hFFFF_FFFE); // masks to Mandelbrot
        write_reg(REG_SEED_R, 32'h8000_0000);
        write_reg(REG_SEED_I, 32'h7FFF_FFFF);
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_MAXIT, 32'd9);
        random_points(60);
        wait_idle();

        write_reg(REG_SEED_R, 32'd0);
        write_reg(REG_SEED_I, 32'd0);
        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_MAXIT, 32'd40);
        random_points(80);
        wait_idle();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(REG_RADIUS, 32'h0400_0000);
        write_reg(REG_MAXIT, 32'd23);
        random_points(200);
        wait_idle();

        // a few deep points at the largest limit
        write_reg(REG_MAXIT, 32'd65535);
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        random_points(3);
        begin
            in_word_t pt;
            pt.point_real = 32'h0040_0000;
            pt.point_imag = 32'h0000_0000;
            send_point(pt);
        end
        wait_idle();

        write_reg(REG_JULIA, 32'd0);
        write_reg(REG_MAXIT, 32'd15);
        write_reg(REG_RADIUS, RADIUS_RST);
        random_points(100);
        wait_idle();

        if (mismatches == 0)
            $display("escape_time_fractal_pixel_core regression: pass");
        else
            $display("escape_time_fractal_pixel_core regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/etf_pkg.sv
design/etf_div_cell.sv
design/etf_iter.sv
design/escape_time_fractal_pixel_core.sv
tb/sv/tb_escape_time_fractal_pixel_core.sv
